[rtl/tcw_pkg.sv]
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 4;

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int TAB_MOD_W = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam int TAB_CNT_W = $clog2(TAB_WIDTH + 1);

  localparam int OP_W      = 2;
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 8;
  localparam int RD_ROW_W  = 5;
  localparam int RD_COL_W  = 7;
  localparam int CUR_COL_W = 7;
  localparam int CUR_ROW_W = 5;
  localparam int POS_W     = 11;

  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;
  localparam logic [CHAR_W-1:0]  CH_TAB      = 8'd9;
  localparam logic [CHAR_W-1:0]  CH_NEWLINE  = 8'd10;
  localparam logic [CHAR_W-1:0]  CH_RETURN   = 8'd13;
  localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'd32;
  localparam logic [CHAR_W-1:0]  CH_BLANK    = 8'd0;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_PUT,
    S_SCROLL,
    S_CLEAR,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } cell_pos_t;

  typedef struct packed {
    logic               we_char;
    logic               we_color;
    logic               re;
    logic [CHAR_W-1:0]  wchar;
    logic [COLOR_W-1:0] wcolor;
  } mem_ctl_t;

  typedef struct packed {
    logic               done;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [CHAR_W-1:0]  cell_char;
    logic [COLOR_W-1:0] cell_color;
  } result_t;

endpackage

[rtl/tcw_ram.sv]
`timescale 1ns / 1ps
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/tcw_addr_unit.sv]
`timescale 1ns / 1ps
module tcw_addr_unit import tcw_pkg::*; (
  input  cell_pos_t         pos,
  input  logic [ROW_W-1:0]  top_row,
  output logic [ADDR_W-1:0] addr
);

  logic [ROW_W:0]   row_sum;
  logic [ROW_W-1:0] phys_row;

  // rows live in a ring; top_row is the physical row shown first
  always_comb begin
    row_sum = {1'b0, pos.row} + {1'b0, top_row};
    if (row_sum >= (ROW_W + 1)'(ROWS)) begin
      row_sum = row_sum - (ROW_W + 1)'(ROWS);
    end
    phys_row = row_sum[ROW_W-1:0];
    addr = ADDR_W'(phys_row) * ADDR_W'(COLUMNS) + ADDR_W'(pos.col);
  end

endmodule

[rtl/tcw_ctrl.sv]
`timescale 1ns / 1ps
module tcw_ctrl import tcw_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [OP_W-1:0]     operation,
  input  logic [CHAR_W-1:0]   char_code,
  input  logic [RD_ROW_W-1:0] read_row,
  input  logic [RD_COL_W-1:0] read_column,
  input  logic                cfg_write,
  input  logic [COLOR_W-1:0]  cfg_data,
  input  logic [CHAR_W-1:0]   rdata_char,
  input  logic [COLOR_W-1:0]  rdata_color,
  output logic                busy,
  output cell_pos_t           pos,
  output logic [ROW_W-1:0]    top_row,
  output mem_ctl_t            mem,
  output result_t             res
);

  localparam logic [COL_W-1:0]     LAST_COL = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]     LAST_ROW = ROW_W'(ROWS - 1);
  localparam logic [TAB_MOD_W-1:0] LAST_MOD = TAB_MOD_W'(TAB_WIDTH - 1);

  state_t               state, state_next;
  logic [COL_W-1:0]     col, col_next;
  logic [ROW_W-1:0]     row, row_next;
  logic [TAB_MOD_W-1:0] col_mod, col_mod_next;
  logic [ROW_W-1:0]     top_row_next;
  logic [TAB_CNT_W-1:0] spaces, spaces_next;
  logic [CHAR_W-1:0]    ch_lat, ch_lat_next;
  logic [COL_W-1:0]     sw_col, sw_col_next;
  logic [ROW_W-1:0]     sw_row, sw_row_next;
  logic [COLOR_W-1:0]   blank_color, blank_color_next;
  logic [COLOR_W-1:0]   fill_color;
  logic [CHAR_W-1:0]    cell_char, cell_char_next;
  logic [COLOR_W-1:0]   cell_color, cell_color_next;
  logic                 in_grid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      col         <= '0;
      row         <= '0;
      col_mod     <= '0;
      top_row     <= '0;
      spaces      <= '0;
      sw_col      <= '0;
      sw_row      <= '0;
      blank_color <= RESET_COLOR;
      fill_color  <= RESET_COLOR;
    end else begin
      state       <= state_next;
      col         <= col_next;
      row         <= row_next;
      col_mod     <= col_mod_next;
      top_row     <= top_row_next;
      spaces      <= spaces_next;
      sw_col      <= sw_col_next;
      sw_row      <= sw_row_next;
      blank_color <= blank_color_next;
      if (cfg_write) begin
        fill_color <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ch_lat     <= ch_lat_next;
    cell_char  <= cell_char_next;
    cell_color <= cell_color_next;
  end

  assign in_grid = (int'(read_row) < ROWS) && (int'(read_column) < COLUMNS);
  assign busy    = (state != S_IDLE);

  always_comb begin
    state_next       = state;
    col_next         = col;
    row_next         = row;
    col_mod_next     = col_mod;
    top_row_next     = top_row;
    spaces_next      = spaces;
    ch_lat_next      = ch_lat;
    sw_col_next      = sw_col;
    sw_row_next      = sw_row;
    blank_color_next = blank_color;
    cell_char_next   = cell_char;
    cell_color_next  = cell_color;
    pos              = '{row: row, col: col};
    mem              = '{we_char: 1'b0, we_color: 1'b0, re: 1'b0,
                         wchar: CH_BLANK, wcolor: blank_color};
    res              = '{done: 1'b0, row: row, col: col,
                         cell_char: cell_char, cell_color: cell_color};

    case (state)
      S_IDLE: begin
        pos = '{row: ROW_W'(read_row), col: COL_W'(read_column)};
        if (start) begin
          cell_char_next  = '0;
          cell_color_next = '0;
          case (op_t'(operation))
            OP_PUT: begin
              ch_lat_next = char_code;
              case (char_code)
                CH_NEWLINE: begin
                  col_next     = '0;
                  col_mod_next = '0;
                  spaces_next  = '0;
                  if (row == LAST_ROW) begin
                    top_row_next = (top_row == LAST_ROW) ? '0 : top_row + 1'b1;
                    sw_col_next  = '0;
                    state_next   = S_SCROLL;
                  end else begin
                    row_next   = row + 1'b1;
                    state_next = S_DONE;
                  end
                end
                CH_RETURN: begin
                  col_next     = '0;
                  col_mod_next = '0;
                  state_next   = S_DONE;
                end
                CH_TAB: begin
                  spaces_next = TAB_CNT_W'(TAB_WIDTH) - TAB_CNT_W'(col_mod);
                  ch_lat_next = CH_SPACE;
                  state_next  = S_PUT;
                end
                default: begin
                  spaces_next = TAB_CNT_W'(1);
                  state_next  = S_PUT;
                end
              endcase
            end
            OP_CLEAR: begin
              col_next         = '0;
              row_next         = '0;
              col_mod_next     = '0;
              top_row_next     = '0;
              sw_col_next      = '0;
              sw_row_next      = '0;
              blank_color_next = fill_color;
              state_next       = S_CLEAR;
            end
            OP_READ: begin
              if (in_grid) begin
                mem.re     = 1'b1;
                state_next = S_READ;
              end else begin
                state_next = S_DONE;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_PUT: begin
        mem.we_char = 1'b1;
        mem.wchar   = ch_lat;
        spaces_next = spaces - 1'b1;
        if (col == LAST_COL) begin
          col_next     = '0;
          col_mod_next = '0;
          if (row == LAST_ROW) begin
            top_row_next = (top_row == LAST_ROW) ? '0 : top_row + 1'b1;
            sw_col_next  = '0;
            state_next   = S_SCROLL;
          end else begin
            row_next   = row + 1'b1;
            state_next = (spaces == TAB_CNT_W'(1)) ? S_DONE : S_PUT;
          end
        end else begin
          col_next     = col + 1'b1;
          col_mod_next = (col_mod == LAST_MOD) ? '0 : col_mod + 1'b1;
          state_next   = (spaces == TAB_CNT_W'(1)) ? S_DONE : S_PUT;
        end
      end

      // blank the new bottom row
      S_SCROLL: begin
        pos          = '{row: LAST_ROW, col: sw_col};
        mem.we_char  = 1'b1;
        mem.we_color = 1'b1;
        mem.wcolor   = fill_color;
        sw_col_next  = sw_col + 1'b1;
        if (sw_col == LAST_COL) begin
          state_next = (spaces != '0) ? S_PUT : S_DONE;
        end
      end

      S_INIT, S_CLEAR: begin
        pos          = '{row: sw_row, col: sw_col};
        mem.we_char  = 1'b1;
        mem.we_color = 1'b1;
        if (sw_col == LAST_COL) begin
          sw_col_next = '0;
          if (sw_row == LAST_ROW) begin
            state_next = (state == S_INIT) ? S_IDLE : S_DONE;
          end else begin
            sw_row_next = sw_row + 1'b1;
          end
        end else begin
          sw_col_next = sw_col + 1'b1;
        end
      end

      S_READ: begin
        cell_char_next  = rdata_char;
        cell_color_next = rdata_color;
        state_next      = S_DONE;
      end

      S_DONE: begin
        res.done   = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/text_console_writer_top.sv]
`timescale 1ns / 1ps
// Text console with an 80x25 grid of char/color cells and a cursor. A word is
// taken when start is high and busy is low; its result appears for exactly
// one cycle with done high and cannot be held off, so the receiver must take
// it then. Work is done by one address unit and a single-port cell memory
// (char and color halves) under a small sequencer, one cell access a cycle:
// a printable put writes one cell, an in-grid read reads one, return and
// newline move the cursor, a tab writes spaces up to the next tab stop,
// each scroll blanks the new bottom row cell by cell (rows sit in a ring, so
// nothing is copied), and clear blanks every cell. After reset busy stays
// high for a clearing pass over every cell; cfg_write is taken at any time.
module text_console_writer_top import tcw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_W-1:0]      operation,
  input  logic [CHAR_W-1:0]    char_code,
  input  logic [RD_ROW_W-1:0]  read_row,
  input  logic [RD_COL_W-1:0]  read_column,
  input  logic                 cfg_write,
  input  logic [COLOR_W-1:0]   cfg_data,
  output logic                 done,
  output logic [CUR_COL_W-1:0] cursor_column,
  output logic [CUR_ROW_W-1:0] cursor_row,
  output logic [POS_W-1:0]     cursor_position,
  output logic [CHAR_W-1:0]    cell_char,
  output logic [COLOR_W-1:0]   cell_color
);

  cell_pos_t          pos;
  logic [ROW_W-1:0]   top_row;
  logic [ADDR_W-1:0]  addr;
  mem_ctl_t           mem;
  result_t            res;
  logic [CHAR_W-1:0]  rdata_char;
  logic [COLOR_W-1:0] rdata_color;

  tcw_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .operation   (operation),
    .char_code   (char_code),
    .read_row    (read_row),
    .read_column (read_column),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .rdata_char  (rdata_char),
    .rdata_color (rdata_color),
    .busy        (busy),
    .pos         (pos),
    .top_row     (top_row),
    .mem         (mem),
    .res         (res)
  );

  tcw_addr_unit u_addr (
    .pos     (pos),
    .top_row (top_row),
    .addr    (addr)
  );

  tcw_ram #(.WIDTH(CHAR_W), .DEPTH(CELLS)) u_char_ram (
    .clk   (clk),
    .we    (mem.we_char),
    .re    (mem.re),
    .addr  (addr),
    .wdata (mem.wchar),
    .rdata (rdata_char)
  );

  tcw_ram #(.WIDTH(COLOR_W), .DEPTH(CELLS)) u_color_ram (
    .clk   (clk),
    .we    (mem.we_color),
    .re    (mem.re),
    .addr  (addr),
    .wdata (mem.wcolor),
    .rdata (rdata_color)
  );

  assign done            = res.done;
  assign cursor_column   = CUR_COL_W'(res.col);
  assign cursor_row      = CUR_ROW_W'(res.row);
  assign cursor_position = POS_W'(ADDR_W'(res.row) * ADDR_W'(COLUMNS) + ADDR_W'(res.col));
  assign cell_char       = res.cell_char;
  assign cell_color      = res.cell_color;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import tcw_pkg::*;

  localparam int STALL_LIMIT = 20000;

  typedef struct {
    bit                  is_cfg;
    logic [COLOR_W-1:0]  color;
    logic [OP_W-1:0]     op;
    logic [CHAR_W-1:0]   ch;
    logic [RD_ROW_W-1:0] rr;
    logic [RD_COL_W-1:0] rc;
  } word_t;

  typedef struct packed {
    logic [CUR_COL_W-1:0] col;
    logic [CUR_ROW_W-1:0] row;
    logic [POS_W-1:0]     pos;
    logic [CHAR_W-1:0]    ch;
    logic [COLOR_W-1:0]   color;
  } cursor_rpt_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [OP_W-1:0]      operation = '0;
  logic [CHAR_W-1:0]    char_code = '0;
  logic [RD_ROW_W-1:0]  read_row = '0;
  logic [RD_COL_W-1:0]  read_column = '0;
  logic                 cfg_write = 1'b0;
  logic [COLOR_W-1:0]   cfg_data = '0;
  logic                 done;
  logic [CUR_COL_W-1:0] cursor_column;
  logic [CUR_ROW_W-1:0] cursor_row;
  logic [POS_W-1:0]     cursor_position;
  logic [CHAR_W-1:0]    cell_char;
  logic [COLOR_W-1:0]   cell_color;

  text_console_writer_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .char_code(char_code),
    .read_row(read_row), .read_column(read_column),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .done(done), .cursor_column(cursor_column), .cursor_row(cursor_row),
    .cursor_position(cursor_position), .cell_char(cell_char),
    .cell_color(cell_color)
  );

  always #10 clk = ~clk;

  word_t       word_q[$];
  cursor_rpt_t cursor_rpt_q[$];

  logic [CHAR_W-1:0]  shadow_char [CELLS];
  logic [COLOR_W-1:0] shadow_color[CELLS];
  int                 shadow_col;
  int                 shadow_row;
  logic [COLOR_W-1:0] shadow_blank_color;

  int errors = 0;
  int stall_cnt = 0;
  int gap_left = 0;
  int burst_left = 0;
  int words_in = 0;
  int results_in = 0;
  int clears_in = 0;
  int reads_in = 0;
  int scroll_cnt = 0;
  int color_writes = 0;

  word_t       seen_word;
  cursor_rpt_t want;
  cursor_rpt_t got;

  function automatic void shadow_reset();
    for (int i = 0; i < CELLS; i++) begin
      shadow_char[i]  = CH_BLANK;
      shadow_color[i] = RESET_COLOR;
    end
    shadow_col = 0;
    shadow_row = 0;
    shadow_blank_color = RESET_COLOR;
  endfunction

  function automatic void shadow_scroll();
    for (int i = 0; i < CELLS - COLUMNS; i++) begin
      shadow_char[i]  = shadow_char[i + COLUMNS];
      shadow_color[i] = shadow_color[i + COLUMNS];
    end
    for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
      shadow_char[i]  = CH_BLANK;
      shadow_color[i] = shadow_blank_color;
    end
    scroll_cnt++;
  endfunction

  function automatic void shadow_wrap();
    if (shadow_col >= COLUMNS) begin
      shadow_col = 0;
      shadow_row++;
    end
    if (shadow_row >= ROWS) begin
      shadow_scroll();
      shadow_row = ROWS - 1;
    end
  endfunction

  function automatic void shadow_print(logic [CHAR_W-1:0] c);
    shadow_char[shadow_row * COLUMNS + shadow_col] = c;
    shadow_col++;
    shadow_wrap();
  endfunction

  function automatic cursor_rpt_t console_predict(word_t w);
    cursor_rpt_t r = '0;
    int          n;
    case (op_t'(w.op))
      OP_PUT: begin
        case (w.ch)
          CH_NEWLINE: begin
            shadow_col = 0;
            shadow_row++;
            shadow_wrap();
          end
          CH_RETURN: shadow_col = 0;
          CH_TAB: begin
            n = TAB_WIDTH - (shadow_col % TAB_WIDTH);
            for (int k = 0; k < n; k++) shadow_print(CH_SPACE);
          end
          default: shadow_print(w.ch);
        endcase
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          shadow_char[i]  = CH_BLANK;
          shadow_color[i] = shadow_blank_color;
        end
        shadow_col = 0;
        shadow_row = 0;
      end
      OP_READ: begin
        if (w.rr < ROWS && w.rc < COLUMNS) begin
          r.ch    = shadow_char[w.rr * COLUMNS + w.rc];
          r.color = shadow_color[w.rr * COLUMNS + w.rc];
        end
      end
      default: ;
    endcase
    r.col = CUR_COL_W'(shadow_col);
    r.row = CUR_ROW_W'(shadow_row);
    r.pos = POS_W'(shadow_row * COLUMNS + shadow_col);
    return r;
  endfunction

  function automatic void push_word(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                    logic [RD_ROW_W-1:0] rr, logic [RD_COL_W-1:0] rc);
    word_t w;
    w.is_cfg = 1'b0;
    w.color  = '0;
    w.op     = op;
    w.ch     = ch;
    w.rr     = rr;
    w.rc     = rc;
    word_q.push_back(w);
  endfunction

  function automatic void push_cfg(logic [COLOR_W-1:0] color);
    word_t w;
    w.is_cfg = 1'b1;
    w.color  = color;
    w.op     = OP_PUT;
    w.ch     = '0;
    w.rr     = '0;
    w.rc     = '0;
    word_q.push_back(w);
  endfunction

  function automatic void add_random(int n);
    int made = 0;
    int k;
    int run;
    while (made < n) begin
      k = $urandom_range(0, 999);
      if (k < 40) begin
        // long line of text to force wraps
        run = $urandom_range(70, 90);
        repeat (run) push_word(OP_PUT, CHAR_W'($urandom_range(32, 126)),
                               RD_ROW_W'($urandom), RD_COL_W'($urandom));
        made += run;
      end else begin
        if (k < 47) begin
          push_word(OP_CLEAR, CHAR_W'($urandom), RD_ROW_W'($urandom), RD_COL_W'($urandom));
        end else if (k < 67) begin
          push_word(OP_NONE, CHAR_W'($urandom), RD_ROW_W'($urandom), RD_COL_W'($urandom));
        end else if (k < 207) begin
          case ($urandom_range(0, 19))
            0: push_word(OP_READ, CHAR_W'($urandom), RD_ROW_W'($urandom_range(ROWS, 31)),
                         RD_COL_W'($urandom));
            1: push_word(OP_READ, CHAR_W'($urandom), RD_ROW_W'($urandom),
                         RD_COL_W'($urandom_range(COLUMNS, 127)));
            default: push_word(OP_READ, CHAR_W'($urandom),
                               RD_ROW_W'($urandom_range(0, ROWS - 1)),
                               RD_COL_W'($urandom_range(0, COLUMNS - 1)));
          endcase
        end else begin
          k = $urandom_range(0, 99);
          if (k < 14)
            push_word(OP_PUT, CH_NEWLINE, RD_ROW_W'($urandom), RD_COL_W'($urandom));
          else if (k < 20)
            push_word(OP_PUT, CH_RETURN, RD_ROW_W'($urandom), RD_COL_W'($urandom));
          else if (k < 30)
            push_word(OP_PUT, CH_TAB, RD_ROW_W'($urandom), RD_COL_W'($urandom));
          else
            push_word(OP_PUT, CHAR_W'($urandom_range(0, 255)), RD_ROW_W'($urandom),
                      RD_COL_W'($urandom));
        end
        made++;
      end
    end
  endfunction

  function automatic int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 100);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start     <= 1'b0;
      cfg_write <= 1'b0;
      gap_left  <= 0;
    end else begin
      cfg_write <= 1'b0;
      if (!start || !busy) begin
        if (gap_left != 0) begin
          start    <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (word_q.size() == 0) begin
          start <= 1'b0;
        end else if (word_q[0].is_cfg) begin
          start <= 1'b0;
          if (!start && !busy && !done && cursor_rpt_q.size() == 0) begin
            cfg_write <= 1'b1;
            cfg_data  <= word_q[0].color;
            void'(word_q.pop_front());
          end
        end else begin
          start       <= 1'b1;
          operation   <= word_q[0].op;
          char_code   <= word_q[0].ch;
          read_row    <= word_q[0].rr;
          read_column <= word_q[0].rc;
          void'(word_q.pop_front());
          gap_left    <= next_gap();
        end
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    if (rst) begin
      shadow_reset();
      stall_cnt <= 0;
    end else begin
      if (cfg_write) begin
        shadow_blank_color = cfg_data;
        color_writes++;
      end
      if (start && !busy) begin
        seen_word.is_cfg = 1'b0;
        seen_word.color  = '0;
        seen_word.op     = operation;
        seen_word.ch     = char_code;
        seen_word.rr     = read_row;
        seen_word.rc     = read_column;
        cursor_rpt_q.push_back(console_predict(seen_word));
        words_in++;
        if (operation == OP_CLEAR) clears_in++;
        if (operation == OP_READ) reads_in++;
      end
      if (done) begin
        got = '{cursor_column, cursor_row, cursor_position, cell_char, cell_color};
        results_in++;
        if (cursor_rpt_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("ERROR %0t: unexpected result col=%0d row=%0d pos=%0d char=%h color=%h",
                     $realtime, got.col, got.row, got.pos, got.ch, got.color);
        end else begin
          want = cursor_rpt_q.pop_front();
          if (got.col !== want.col || got.row !== want.row || got.pos !== want.pos ||
              got.ch !== want.ch || got.color !== want.color) begin
            errors++;
            if (errors <= 10)
              $display({"ERROR %0t: exp col=%0d row=%0d pos=%0d char=%h color=%h, ",
                        "got col=%0d row=%0d pos=%0d char=%h color=%h"}, $realtime,
                       want.col, want.row, want.pos, want.ch, want.color,
                       got.col, got.row, got.pos, got.ch, got.color);
          end
        end
      end
      if ((start && !busy) || done || cfg_write) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    wait (stall_cnt >= STALL_LIMIT);
    $display("stall of %0d cycles, %0d results outstanding", stall_cnt, cursor_rpt_q.size());
    $display("text_console_writer_top test failed");
    $finish;
  end

  initial begin
    push_word(OP_PUT, 8'h48, '0, '0);
    push_word(OP_PUT, 8'hFF, '1, '1);
    push_word(OP_PUT, 8'h00, '0, '0);
    push_word(OP_READ, 8'h00, 5'd0, 7'd0);
    push_word(OP_READ, 8'hFF, 5'd0, 7'd2);
    push_word(OP_PUT, CH_TAB, '0, '0);
    push_word(OP_PUT, CH_TAB, '0, '0);
    push_word(OP_PUT, 8'h78, '0, '0);
    push_word(OP_READ, 8'h00, 5'd0, 7'd5);
    push_word(OP_PUT, CH_RETURN, '0, '0);
    push_word(OP_PUT, CH_NEWLINE, '0, '0);
    push_word(OP_PUT, CH_TAB, '0, '0);
    push_word(OP_READ, 8'h00, 5'd24, 7'd79);
    push_word(OP_READ, 8'h00, 5'd25, 7'd0);
    push_word(OP_READ, 8'h00, 5'd31, 7'd127);
    push_word(OP_READ, 8'h00, 5'd0, 7'd80);
    push_word(OP_NONE, 8'hAA, 5'h15, 7'h55);
    push_word(OP_CLEAR, 8'h55, 5'h0A, 7'h2A);
    push_word(OP_READ, 8'h00, 5'd0, 7'd0);
    push_cfg(8'h00);
    add_random(400);
    push_cfg(8'hFF);
    push_word(OP_CLEAR, '0, '0, '0);
    push_word(OP_READ, 8'h00, 5'd12, 7'd40);
    add_random(400);
    push_cfg(COLOR_W'($urandom_range(0, 255)));
    add_random(400);
    push_cfg(COLOR_W'($urandom_range(0, 255)));
    add_random(400);
    push_cfg(RESET_COLOR);
    add_random(400);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (word_q.size() != 0 || start || cursor_rpt_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d words (%0d clears, %0d reads), %0d results, %0d scrolls predicted",
             words_in, clears_in, reads_in, results_in, scroll_cnt);
    $display("%0d color register writes, %0d mismatches", color_writes, errors);
    if (errors == 0 && cursor_rpt_q.size() == 0) begin
      $display("text_console_writer_top test passed");
    end else begin
      $display("text_console_writer_top test failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_addr_unit.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer_top.sv
bench/tb_top.sv
